@@ hw/rtl/avvt_pkg.sv @@
// ----------------------------------------------------------------------------
// avvt_pkg
// Widths, register indexes, reset values and shared types of the apogee and
// vertical velocity tracker.
// ----------------------------------------------------------------------------
package avvt_pkg;

    localparam int ALT_W     = 26;
    localparam int TICK_W    = 32;
    localparam int DROP_W    = 25;
    localparam int RATE_W    = 32;
    localparam int ASC_W     = 31;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 8;

    // altitude difference, one bit wider than an altitude
    localparam int DIFF_W    = ALT_W + 1;
    // magnitude of (difference * 1000) fits in 36 bits
    localparam int DVD_W     = 36;
    localparam int DVS_W     = TICK_W;
    localparam int DIV_CNT_W = $clog2(DVD_W + 1);

    localparam logic [CFG_IDX_W-1:0] REG_ARM_DELAY  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VEL_WINDOW = 8'd1;

    localparam logic [CFG_W-1:0] ARM_DELAY_RST  = 16'd5000;
    localparam logic [CFG_W-1:0] VEL_WINDOW_RST = 16'd200;

    typedef struct packed {
        logic busy;
        logic done;
    } avvt_div_stat_t;

endpackage

@@ hw/rtl/avvt_in_if.sv @@
// ----------------------------------------------------------------------------
// avvt_in_if
// Sample channel: one altitude sample and its millisecond tick per beat.
// ----------------------------------------------------------------------------
interface avvt_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [avvt_pkg::ALT_W-1:0]   altitude_cm;
    logic        [avvt_pkg::TICK_W-1:0]  tick_ms;

    modport source (output valid, output altitude_cm, output tick_ms, input ready);
    modport sink   (input valid, input altitude_cm, input tick_ms, output ready);
endinterface

@@ hw/rtl/avvt_out_if.sv @@
// ----------------------------------------------------------------------------
// avvt_out_if
// Result channel: tracker status for one sample per beat.
// ----------------------------------------------------------------------------
interface avvt_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [avvt_pkg::ALT_W-1:0]   peak_altitude_cm;
    logic        [avvt_pkg::DROP_W-1:0]  drop_from_peak_cm;
    logic signed [avvt_pkg::RATE_W-1:0]  climb_rate_cms;
    logic        [avvt_pkg::ASC_W-1:0]   fastest_ascent_cms;
    logic signed [avvt_pkg::RATE_W-1:0]  fastest_descent_cms;
    logic                                rate_updated;

    modport source (output valid, output peak_altitude_cm, output drop_from_peak_cm,
                    output climb_rate_cms, output fastest_ascent_cms,
                    output fastest_descent_cms, output rate_updated, input ready);
    modport sink   (input valid, input peak_altitude_cm, input drop_from_peak_cm,
                    input climb_rate_cms, input fastest_ascent_cms,
                    input fastest_descent_cms, input rate_updated, output ready);
endinterface

@@ hw/rtl/avvt_cfg_if.sv @@
// ----------------------------------------------------------------------------
// avvt_cfg_if
// Configuration write channel: register index and write data per beat.
// ----------------------------------------------------------------------------
interface avvt_cfg_if;
    logic                                 valid;
    logic                                 ready;
    logic [avvt_pkg::CFG_IDX_W-1:0]       index;
    logic [avvt_pkg::CFG_W-1:0]           data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/avvt_div.sv @@
// ----------------------------------------------------------------------------
// avvt_div
// Bit-serial restoring divider: the dividend shifts out one bit per cycle
// while the quotient shifts in behind it.
// ----------------------------------------------------------------------------
module avvt_div
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [avvt_pkg::DVD_W-1:0]    dividend,
    input  logic [avvt_pkg::DVS_W-1:0]    divisor,
    output logic [avvt_pkg::DVD_W-1:0]    quotient,
    output avvt_pkg::avvt_div_stat_t      stat
);

    logic [avvt_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic [avvt_pkg::DIV_CNT_W-1:0] cnt_next;
    logic                           done_reg;
    logic                           done_next;
    logic [avvt_pkg::DVS_W-1:0]     rem_reg;
    logic [avvt_pkg::DVS_W-1:0]     rem_next;
    logic [avvt_pkg::DVD_W-1:0]     quo_reg;
    logic [avvt_pkg::DVD_W-1:0]     quo_next;
    logic [avvt_pkg::DVS_W-1:0]     dvs_reg;
    logic [avvt_pkg::DVS_W:0]       rem_sh;
    logic [avvt_pkg::DVS_W+1:0]     trial;
    logic                           fits;

    // shift in the next dividend bit, try to subtract
    assign rem_sh = {rem_reg, quo_reg[avvt_pkg::DVD_W-1]};
    assign trial  = {1'b0, rem_sh} - {2'b00, dvs_reg};
    assign fits   = ~trial[avvt_pkg::DVS_W+1];

    always_comb
    begin
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            cnt_next = avvt_pkg::DIV_CNT_W'(avvt_pkg::DVD_W);
            rem_next = '0;
            quo_next = dividend;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next  = cnt_reg - avvt_pkg::DIV_CNT_W'(1);
            done_next = (cnt_reg == avvt_pkg::DIV_CNT_W'(1));
            rem_next  = fits ? trial[avvt_pkg::DVS_W-1:0] : rem_sh[avvt_pkg::DVS_W-1:0];
            quo_next  = {quo_reg[avvt_pkg::DVD_W-2:0], fits};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start)
        begin
            dvs_reg <= divisor;
        end
    end

    assign quotient  = quo_reg;
    assign stat.busy = (cnt_reg != '0);
    assign stat.done = done_reg;

endmodule

@@ hw/rtl/apogee_and_vertical_velocity_tracker_core.sv @@
// ----------------------------------------------------------------------------
// apogee_and_vertical_velocity_tracker_core
// Peak altitude, drop from peak and windowed vertical velocity tracker.
// ----------------------------------------------------------------------------
// One sample is in flight at a time. A sample that does not recompute the
// velocity (not armed, or window not yet exceeded) goes through calc, eval and
// finish before its result is registered; one that recomputes it also goes
// through multiply, divide and saturate, the bit-serial divider retiring one
// quotient bit per cycle over a 36-bit dividend. The next sample is taken as
// soon as the result is in the output register, even while it still waits to be read.
// The configuration port always accepts; write it only while the block is idle.
module apogee_and_vertical_velocity_tracker_core
(
    input  logic        clk,
    input  logic        rst_n,
    avvt_cfg_if.sink    cfg,
    avvt_in_if.sink     sample,
    avvt_out_if.source  result
);

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_CALC = 7'b0000010,
        ST_EVAL = 7'b0000100,
        ST_MUL  = 7'b0001000,
        ST_DIV  = 7'b0010000,
        ST_SAT  = 7'b0100000,
        ST_FIN  = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // configuration
    logic [avvt_pkg::CFG_W-1:0]          arm_delay_reg;
    logic [avvt_pkg::CFG_W-1:0]          vel_window_reg;

    // tracker state
    logic signed [avvt_pkg::ALT_W-1:0]   peak_reg;
    logic signed [avvt_pkg::ALT_W-1:0]   ref_alt_reg;
    logic [avvt_pkg::TICK_W-1:0]         ref_tick_reg;
    logic signed [avvt_pkg::RATE_W-1:0]  climb_reg;
    logic [avvt_pkg::ASC_W-1:0]          ascent_reg;
    logic signed [avvt_pkg::RATE_W-1:0]  descent_reg;

    // per-sample working registers
    logic signed [avvt_pkg::ALT_W-1:0]   alt_reg;
    logic [avvt_pkg::TICK_W-1:0]         tick_reg;
    logic                                armed_reg;
    logic                                upd_reg;
    logic [avvt_pkg::TICK_W-1:0]         elapsed_reg;
    logic [avvt_pkg::DIFF_W-1:0]         diff_reg;
    logic                                neg_reg;
    logic [avvt_pkg::ALT_W-1:0]          absdiff_reg;
    logic [avvt_pkg::DROP_W-1:0]         drop_reg;

    // output register
    logic                                res_valid_reg;
    logic signed [avvt_pkg::ALT_W-1:0]   res_peak_reg;
    logic [avvt_pkg::DROP_W-1:0]         res_drop_reg;
    logic signed [avvt_pkg::RATE_W-1:0]  res_climb_reg;
    logic [avvt_pkg::ASC_W-1:0]          res_ascent_reg;
    logic signed [avvt_pkg::RATE_W-1:0]  res_descent_reg;
    logic                                res_upd_reg;

    logic                                in_beat;
    logic                                out_free;
    logic                                armed_now;
    logic                                upd_now;
    logic [avvt_pkg::DIFF_W-1:0]         neg_diff;
    logic [avvt_pkg::DIFF_W-1:0]         drop_raw;
    logic [avvt_pkg::DROP_W-1:0]         drop_sat;
    logic [avvt_pkg::DVD_W-1:0]          mag;
    logic [avvt_pkg::DVD_W-1:0]          quo;
    logic                                ovf_pos;
    logic                                ovf_neg;
    logic [avvt_pkg::RATE_W-1:0]         neg_quo;
    logic signed [avvt_pkg::RATE_W-1:0]  climb_sat;
    logic                                asc_gt;
    logic                                desc_lt;
    logic [avvt_pkg::ASC_W-1:0]          ascent_new;
    logic signed [avvt_pkg::RATE_W-1:0]  descent_new;
    avvt_pkg::avvt_div_stat_t            div_stat;

    assign cfg.ready    = 1'b1;
    assign sample.ready = (state_reg == ST_IDLE);
    assign in_beat      = sample.valid && sample.ready;
    assign out_free     = !res_valid_reg || result.ready;

    assign armed_now = (tick_reg > {16'b0, arm_delay_reg});
    assign upd_now   = armed_reg && (elapsed_reg > {16'b0, vel_window_reg});

    // armed: peak >= altitude, so the difference is never negative
    assign neg_diff = -diff_reg;
    assign drop_raw = {peak_reg[avvt_pkg::ALT_W-1], peak_reg}
                    - {alt_reg[avvt_pkg::ALT_W-1], alt_reg};
    assign drop_sat = (drop_raw[avvt_pkg::DIFF_W-1:avvt_pkg::DROP_W] != '0)
                    ? '1 : drop_raw[avvt_pkg::DROP_W-1:0];

    // |diff| * 1000 = |diff| * (1024 - 32 + 8)
    assign mag = {absdiff_reg, 10'b0}
               - {5'b0, absdiff_reg, 5'b0}
               + {7'b0, absdiff_reg, 3'b0};

    assign ovf_pos   = (quo[avvt_pkg::DVD_W-1:avvt_pkg::RATE_W-1] != '0);
    assign ovf_neg   = (quo[avvt_pkg::DVD_W-1:avvt_pkg::RATE_W] != '0)
                    || (quo[avvt_pkg::RATE_W-1] && (quo[avvt_pkg::RATE_W-2:0] != '0));
    assign neg_quo   = -quo[avvt_pkg::RATE_W-1:0];
    assign climb_sat = neg_reg
                     ? (ovf_neg ? {1'b1, {(avvt_pkg::RATE_W-1){1'b0}}} : neg_quo)
                     : (ovf_pos ? {1'b0, {(avvt_pkg::RATE_W-1){1'b1}}}
                                : quo[avvt_pkg::RATE_W-1:0]);

    assign asc_gt      = armed_reg && !climb_reg[avvt_pkg::RATE_W-1]
                      && (climb_reg[avvt_pkg::ASC_W-1:0] > ascent_reg);
    assign desc_lt     = armed_reg && (climb_reg < descent_reg);
    assign ascent_new  = asc_gt ? climb_reg[avvt_pkg::ASC_W-1:0] : ascent_reg;
    assign descent_new = desc_lt ? climb_reg : descent_reg;

    avvt_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == ST_MUL),
        .dividend (mag),
        .divisor  (elapsed_reg),
        .quotient (quo),
        .stat     (div_stat)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (in_beat) state_next = ST_CALC;
            ST_CALC: state_next = ST_EVAL;
            ST_EVAL: state_next = upd_now ? ST_MUL : ST_FIN;
            ST_MUL:  state_next = ST_DIV;
            ST_DIV:  if (div_stat.done) state_next = ST_SAT;
            ST_SAT:  state_next = ST_FIN;
            ST_FIN:  if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            arm_delay_reg  <= avvt_pkg::ARM_DELAY_RST;
            vel_window_reg <= avvt_pkg::VEL_WINDOW_RST;
            peak_reg       <= '0;
            ref_alt_reg    <= '0;
            ref_tick_reg   <= '0;
            climb_reg      <= '0;
            ascent_reg     <= '0;
            descent_reg    <= '0;
            armed_reg      <= 1'b0;
            upd_reg        <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index == avvt_pkg::REG_ARM_DELAY)
                begin
                    arm_delay_reg <= cfg.data;
                end
                else if (cfg.index == avvt_pkg::REG_VEL_WINDOW)
                begin
                    vel_window_reg <= cfg.data;
                end
            end

            if (state_reg == ST_CALC)
            begin
                armed_reg <= armed_now;
                if (armed_now && (alt_reg > peak_reg))
                begin
                    peak_reg <= alt_reg;
                end
            end

            if (state_reg == ST_EVAL)
            begin
                upd_reg <= upd_now;
            end

            if (state_reg == ST_SAT)
            begin
                climb_reg    <= climb_sat;
                ref_alt_reg  <= alt_reg;
                ref_tick_reg <= tick_reg;
            end

            if ((state_reg == ST_FIN) && out_free)
            begin
                ascent_reg    <= ascent_new;
                descent_reg   <= descent_new;
                res_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            alt_reg  <= sample.altitude_cm;
            tick_reg <= sample.tick_ms;
        end
        if (state_reg == ST_CALC)
        begin
            elapsed_reg <= tick_reg - ref_tick_reg;
            diff_reg    <= {alt_reg[avvt_pkg::ALT_W-1], alt_reg}
                         - {ref_alt_reg[avvt_pkg::ALT_W-1], ref_alt_reg};
        end
        if (state_reg == ST_EVAL)
        begin
            neg_reg     <= diff_reg[avvt_pkg::DIFF_W-1];
            absdiff_reg <= diff_reg[avvt_pkg::DIFF_W-1]
                         ? neg_diff[avvt_pkg::ALT_W-1:0] : diff_reg[avvt_pkg::ALT_W-1:0];
            drop_reg    <= armed_reg ? drop_sat : '0;
        end
        if ((state_reg == ST_FIN) && out_free)
        begin
            res_peak_reg    <= peak_reg;
            res_drop_reg    <= drop_reg;
            res_climb_reg   <= climb_reg;
            res_ascent_reg  <= ascent_new;
            res_descent_reg <= descent_new;
            res_upd_reg     <= upd_reg;
        end
    end

    assign result.valid               = res_valid_reg;
    assign result.peak_altitude_cm    = res_peak_reg;
    assign result.drop_from_peak_cm   = res_drop_reg;
    assign result.climb_rate_cms      = res_climb_reg;
    assign result.fastest_ascent_cms  = res_ascent_reg;
    assign result.fastest_descent_cms = res_descent_reg;
    assign result.rate_updated        = res_upd_reg;

    // divider runs only while the sequencer waits for it
    a_div_busy_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.busy || div_stat.done |-> state_reg == ST_DIV)
        else $error("divider active outside divide phase");

    // no new sample while a division is still running
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        sample.ready |-> !div_stat.busy)
        else $error("sample accepted during division");

    // reported rate always lies between fastest descent and fastest ascent
    a_rate_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.fastest_descent_cms <= result.climb_rate_cms)
            && (result.climb_rate_cms <= $signed({1'b0, result.fastest_ascent_cms})))
        else $error("climb rate outside ascent/descent extremes");

endmodule
